// ===== hdl/lpg_pkg.sv =====
package lpg_pkg;

    localparam int COLOUR_BITS = 16;

    // word kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // step direction codes of one axis
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd3
    } t_dir;

    typedef struct packed {
        t_dir x;
        t_dir y;
    } t_dirs;

endpackage

// ===== hdl/lpg_in_if.sv =====
interface lpg_in_if #(
    parameter int COORD_BITS = 8
) ();
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [COORD_BITS-1:0]         start_x;
    logic [COORD_BITS-1:0]         start_y;
    logic [COORD_BITS-1:0]         end_x;
    logic [COORD_BITS-1:0]         end_y;
    logic [lpg_pkg::COLOUR_BITS-1:0] colour;

    modport source (
        output valid, kind, start_x, start_y, end_x, end_y, colour,
        input  ready
    );

    modport sink (
        input  valid, kind, start_x, start_y, end_x, end_y, colour,
        output ready
    );
endinterface

// ===== hdl/lpg_out_if.sv =====
interface lpg_out_if #(
    parameter int COORD_BITS = 8
) ();
    logic                            valid;
    logic                            ready;
    logic [COORD_BITS-1:0]           pixel_x;
    logic [COORD_BITS-1:0]           pixel_y;
    logic [lpg_pkg::COLOUR_BITS-1:0] pixel_colour;
    logic                            last;

    modport source (
        output valid, pixel_x, pixel_y, pixel_colour, last,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_colour, last,
        output ready
    );
endinterface

// ===== hdl/lpg_setup.sv =====
module lpg_setup #(
    parameter int COORD_BITS = 8
) (
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    output logic [COORD_BITS-1:0] o_delta_x,
    output logic [COORD_BITS-1:0] o_delta_y,
    output lpg_pkg::t_dirs        o_dirs,
    output logic [COORD_BITS-1:0] o_major
);
    import lpg_pkg::*;

    always_comb begin
        if (i_end_x > i_start_x) begin
            o_delta_x = i_end_x - i_start_x;
            o_dirs.x  = DIR_UP;
        end else if (i_end_x < i_start_x) begin
            o_delta_x = i_start_x - i_end_x;
            o_dirs.x  = DIR_DOWN;
        end else begin
            o_delta_x = '0;
            o_dirs.x  = DIR_NONE;
        end

        if (i_end_y > i_start_y) begin
            o_delta_y = i_end_y - i_start_y;
            o_dirs.y  = DIR_UP;
        end else if (i_end_y < i_start_y) begin
            o_delta_y = i_start_y - i_end_y;
            o_dirs.y  = DIR_DOWN;
        end else begin
            o_delta_y = '0;
            o_dirs.y  = DIR_NONE;
        end

        o_major = (o_delta_x > o_delta_y) ? o_delta_x : o_delta_y;
    end

endmodule

// ===== hdl/lpg_axis_step.sv =====
module lpg_axis_step #(
    parameter int COORD_BITS = 8
) (
    input  logic [COORD_BITS-1:0] i_pos,
    input  logic [COORD_BITS:0]   i_err,
    input  logic [COORD_BITS-1:0] i_delta,
    input  logic [COORD_BITS-1:0] i_major,
    input  lpg_pkg::t_dir         i_dir,
    output logic [COORD_BITS-1:0] o_pos,
    output logic [COORD_BITS:0]   o_err
);
    import lpg_pkg::*;

    logic [COORD_BITS:0] w_sum;
    logic [COORD_BITS:0] w_major;

    assign w_major = {1'b0, i_major};
    assign w_sum   = i_err + {1'b0, i_delta};

    always_comb begin
        o_err = w_sum;
        o_pos = i_pos;
        if (w_sum > w_major) begin
            o_err = w_sum - w_major;
            case (i_dir)
                DIR_UP:   o_pos = i_pos + COORD_BITS'(1);
                DIR_DOWN: o_pos = i_pos - COORD_BITS'(1);
                default:  o_pos = i_pos;
            endcase
        end
    end

endmodule

// ===== hdl/line_pixel_generator_core.sv =====
// A step word's pixel is loaded into the output register when the word is accepted.
// Throughput: one word per clock; the next word is taken while a pixel waits,
// as long as the output register is empty or drained in the same cycle.
// A load word updates the line state and emits nothing.
// Reset (synchronous, active low) clears the busy flag and the output valid;
// the line registers are loaded by the next load word.
module line_pixel_generator_core #(
    parameter int COORD_BITS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lpg_in_if.sink         i_in,
    lpg_out_if.source      o_out
);
    import lpg_pkg::*;

    localparam int CNT_BITS = COORD_BITS + 1;

    // line state
    logic                   r_busy,        n_busy;
    logic [COORD_BITS-1:0]  r_cur_x,       n_cur_x;
    logic [COORD_BITS-1:0]  r_cur_y,       n_cur_y;
    logic [COORD_BITS-1:0]  r_delta_x,     n_delta_x;
    logic [COORD_BITS-1:0]  r_delta_y,     n_delta_y;
    t_dirs                  r_dirs,        n_dirs;
    logic [COORD_BITS-1:0]  r_major,       n_major;
    logic [COORD_BITS:0]    r_err_x,       n_err_x;
    logic [COORD_BITS:0]    r_err_y,       n_err_y;
    logic [CNT_BITS-1:0]    r_pixels_left, n_pixels_left;
    logic [COLOUR_BITS-1:0] r_colour,      n_colour;

    // output register
    logic                   r_out_valid;
    logic [COORD_BITS-1:0]  r_out_x;
    logic [COORD_BITS-1:0]  r_out_y;
    logic [COLOUR_BITS-1:0] r_out_colour;
    logic                   r_out_last;

    logic                   w_accept;
    logic                   w_emit;

    // load setup results
    logic [COORD_BITS-1:0]  w_ld_delta_x;
    logic [COORD_BITS-1:0]  w_ld_delta_y;
    t_dirs                  w_ld_dirs;
    logic [COORD_BITS-1:0]  w_ld_major;

    // per-axis step results
    logic [COORD_BITS-1:0]  w_step_x;
    logic [COORD_BITS-1:0]  w_step_y;
    logic [COORD_BITS:0]    w_step_err_x;
    logic [COORD_BITS:0]    w_step_err_y;

    // Take a word whenever the output register is free or drains this cycle.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    // A step word only produces a pixel while a line is active.
    assign w_emit     = w_accept && (i_in.kind == KIND_STEP) && r_busy;

    lpg_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .i_start_x (i_in.start_x),
        .i_start_y (i_in.start_y),
        .i_end_x   (i_in.end_x),
        .i_end_y   (i_in.end_y),
        .o_delta_x (w_ld_delta_x),
        .o_delta_y (w_ld_delta_y),
        .o_dirs    (w_ld_dirs),
        .o_major   (w_ld_major)
    );

    lpg_axis_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step_x (
        .i_pos   (r_cur_x),
        .i_err   (r_err_x),
        .i_delta (r_delta_x),
        .i_major (r_major),
        .i_dir   (r_dirs.x),
        .o_pos   (w_step_x),
        .o_err   (w_step_err_x)
    );

    lpg_axis_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step_y (
        .i_pos   (r_cur_y),
        .i_err   (r_err_y),
        .i_delta (r_delta_y),
        .i_major (r_major),
        .i_dir   (r_dirs.y),
        .o_pos   (w_step_y),
        .o_err   (w_step_err_y)
    );

    always_comb begin
        n_busy        = r_busy;
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        n_delta_x     = r_delta_x;
        n_delta_y     = r_delta_y;
        n_dirs        = r_dirs;
        n_major       = r_major;
        n_err_x       = r_err_x;
        n_err_y       = r_err_y;
        n_pixels_left = r_pixels_left;
        n_colour      = r_colour;

        if (w_accept && (i_in.kind == KIND_LOAD)) begin
            // Replace any line in flight; count is distance + 2 pixels
            // since the start pixel goes out twice.
            n_busy        = 1'b1;
            n_cur_x       = i_in.start_x;
            n_cur_y       = i_in.start_y;
            n_delta_x     = w_ld_delta_x;
            n_delta_y     = w_ld_delta_y;
            n_dirs        = w_ld_dirs;
            n_major       = w_ld_major;
            n_err_x       = '0;
            n_err_y       = '0;
            n_pixels_left = {1'b0, w_ld_major} + CNT_BITS'(2);
            n_colour      = i_in.colour;
        end else if (w_emit) begin
            // Advance both error sums and coordinates after emitting.
            n_cur_x = w_step_x;
            n_cur_y = w_step_y;
            n_err_x = w_step_err_x;
            n_err_y = w_step_err_y;
            if (r_pixels_left != '0) begin
                n_pixels_left = r_pixels_left - CNT_BITS'(1);
            end
            n_busy = (n_pixels_left != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x       <= n_cur_x;
        r_cur_y       <= n_cur_y;
        r_delta_x     <= n_delta_x;
        r_delta_y     <= n_delta_y;
        r_dirs        <= n_dirs;
        r_major       <= n_major;
        r_err_x       <= n_err_x;
        r_err_y       <= n_err_y;
        r_pixels_left <= n_pixels_left;
        r_colour      <= n_colour;
    end

    // Output register: load on emit, drop valid once the sink takes the word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_x      <= r_cur_x;
            r_out_y      <= r_cur_y;
            r_out_colour <= r_colour;
            r_out_last   <= (r_pixels_left == CNT_BITS'(1));
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.pixel_x      = r_out_x;
    assign o_out.pixel_y      = r_out_y;
    assign o_out.pixel_colour = r_out_colour;
    assign o_out.last         = r_out_last;

`ifndef SYNTHESIS
    // An active line always has pixels left to give.
    a_busy_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pixels_left != '0))
        else $error("busy with zero pixel count");

    // Error sums never exceed the major distance while a line is active.
    a_err_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ((r_err_x <= {1'b0, r_major}) && (r_err_y <= {1'b0, r_major})))
        else $error("error sum above major distance");

    // Emitting the final pixel ends the line, and it carries the last flag.
    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && (r_pixels_left == CNT_BITS'(1))) |=> (!r_busy && r_out_last))
        else $error("final pixel did not end the line");

    // A load starts a fresh line with cleared error sums.
    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.kind == KIND_LOAD))
            |=> (r_busy && (r_err_x == '0) && (r_err_y == '0)))
        else $error("load did not start a clean line");
`endif

endmodule
